// File: hdl/position_history_interpolator_unit_assert.svh
// Assertion macros for the position history interpolator.
// Included by files that carry concurrent checks; clocked on clk_i, reset rst_ni.
`ifndef POSITION_HISTORY_INTERPOLATOR_UNIT_ASSERT_SVH
`define POSITION_HISTORY_INTERPOLATOR_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define PHI_ASSERT_NOW(lbl, ant, con) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (con)) \
    else $error("phi check failed");
// Next-cycle implication.
`define PHI_ASSERT_NXT(lbl, ant, con) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (con)) \
    else $error("phi check failed");
`else
`define PHI_ASSERT_NOW(lbl, ant, con)
`define PHI_ASSERT_NXT(lbl, ant, con)
`endif
`endif

// File: hdl/phi_pkg.sv
// Shared types and constants of the position history interpolator.
// No dependencies; used by the controller, datapath and top level.
package phi_pkg;

  localparam int LatW            = 31;
  localparam int LonW            = 32;
  localparam int TimeW           = 32;
  localparam int QualW           = 4;
  localparam int HistoryDepthDef = 64;
  // Magnitude of a coordinate difference and the full product width
  localparam int DiffW           = 33;
  localparam int ProdW           = DiffW + TimeW;
  localparam int MulSteps        = TimeW;
  localparam int DivSteps        = ProdW;
  localparam int StepW           = 7;

  localparam logic CmdAdd   = 1'b0;
  localparam logic CmdQuery = 1'b1;

  typedef enum logic [2:0] {
    SelCur,
    SelFirst,
    SelNewest,
    SelOldest,
    SelInterp
  } res_sel_e;

  typedef struct packed {
    logic signed [LatW-1:0] lat;
    logic signed [LonW-1:0] lon;
    logic [TimeW-1:0]       tm;
  } entry_t;

  localparam int EntryW = $bits(entry_t);

  typedef struct packed {
    logic     add_we;
    logic     query_ld;
    logic     ld_first;
    logic     ld_pair;
    logic     advance;
    logic     mul_init;
    logic     mul_step;
    logic     div_init;
    logic     div_step;
    logic     out_load;
    res_sel_e sel;
  } dp_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic cnt_one;
    logic brk;
    logic eq;
    logic last;
    logic tge;
    logic mul_last;
    logic div_last;
    logic out_free;
  } dp_stat_t;

endpackage

// File: hdl/phi_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module phi_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/phi_ctrl.sv
// Controller of the position history interpolator: sequences add, walk,
// multiply, divide and output. Depends on phi_pkg.
module phi_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              command_i,
  output logic              in_ready_o,
  input  phi_pkg::dp_stat_t stat_i,
  output phi_pkg::dp_cmd_t  cmd_o
);

  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StRd0  = 4'd1;
  localparam logic [3:0] StLd0  = 4'd2;
  localparam logic [3:0] StRd   = 4'd3;
  localparam logic [3:0] StChk  = 4'd4;
  localparam logic [3:0] StDec  = 4'd5;
  localparam logic [3:0] StMul  = 4'd6;
  localparam logic [3:0] StDiv  = 4'd7;
  localparam logic [3:0] StOut  = 4'd8;

  logic [3:0]        state_q, state_d;
  phi_pkg::res_sel_e sel_q, sel_d;
  logic              accept;

  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i && in_ready_o;

  // Next state and datapath commands
  always_comb begin
    state_d = state_q;
    sel_d   = sel_q;
    cmd_o   = '0;
    cmd_o.sel = sel_q;
    case (state_q)
      StIdle: begin
        if (accept) begin
          if (command_i == phi_pkg::CmdAdd) begin
            cmd_o.add_we = 1'b1;
          end else begin
            cmd_o.query_ld = 1'b1;
            if (stat_i.cnt_zero) begin
              sel_d   = phi_pkg::SelCur;
              state_d = StOut;
            end else begin
              state_d = StRd0;
            end
          end
        end
      end
      StRd0: state_d = StLd0;
      StLd0: begin
        cmd_o.ld_first = 1'b1;
        if (stat_i.cnt_one) begin
          sel_d   = phi_pkg::SelFirst;
          state_d = StOut;
        end else begin
          state_d = StRd;
        end
      end
      StRd: state_d = StChk;
      StChk: begin
        cmd_o.ld_pair = 1'b1;
        state_d       = StDec;
      end
      StDec: begin
        if (stat_i.brk) begin
          if (stat_i.eq) begin
            sel_d   = phi_pkg::SelFirst;
            state_d = StOut;
          end else begin
            cmd_o.mul_init = 1'b1;
            state_d        = StMul;
          end
        end else if (stat_i.last) begin
          sel_d   = stat_i.tge ? phi_pkg::SelNewest : phi_pkg::SelOldest;
          state_d = StOut;
        end else begin
          cmd_o.advance = 1'b1;
          state_d       = StRd;
        end
      end
      StMul: begin
        cmd_o.mul_step = 1'b1;
        if (stat_i.mul_last) begin
          cmd_o.div_init = 1'b1;
          state_d        = StDiv;
        end
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          sel_d   = phi_pkg::SelInterp;
          state_d = StOut;
        end
      end
      StOut: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      sel_q   <= phi_pkg::SelCur;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
    end
  end

endmodule

// File: hdl/phi_dp.sv
// Datapath of the position history interpolator: history ring, pair walk,
// shift-add multiplier, restoring divider and output word register.
// Depends on phi_pkg and phi_ram.
module phi_dp #(
  parameter int HistoryDepth = phi_pkg::HistoryDepthDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic signed [phi_pkg::LatW-1:0]   lat_in_i,
  input  logic signed [phi_pkg::LonW-1:0]   lon_in_i,
  input  logic [phi_pkg::QualW-1:0]         fix_quality_i,
  input  logic [phi_pkg::TimeW-1:0]         time_ms_i,
  input  phi_pkg::dp_cmd_t                  cmd_i,
  output phi_pkg::dp_stat_t                 stat_o,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic signed [phi_pkg::LatW-1:0]   lat_out_o,
  output logic signed [phi_pkg::LonW-1:0]   lon_out_o,
  output logic                              interp_valid_o
);

  localparam int IdxW  = $clog2(HistoryDepth);
  localparam int CntW  = $clog2(HistoryDepth + 1);
  localparam int DiffW = phi_pkg::DiffW;
  localparam int ProdW = phi_pkg::ProdW;
  localparam int TimeW = phi_pkg::TimeW;
  localparam int StepW = phi_pkg::StepW;

  // Ring pointers and current position
  logic [IdxW-1:0]                  oldest_q;
  logic [CntW-1:0]                  count_q;
  logic signed [phi_pkg::LatW-1:0]  cur_lat_q;
  logic signed [phi_pkg::LonW-1:0]  cur_lon_q;

  // Walk registers
  logic [TimeW-1:0]   t_q;
  logic [IdxW-1:0]    pos_q;
  phi_pkg::entry_t    a_q, b_q, o_q, rdata;
  logic               brk_q, eq_q, last_q, tge_q;

  // Arithmetic lanes: 0 latitude, 1 longitude
  logic [TimeW-1:0]   mplier_q, den_q;
  logic [ProdW-1:0]   acc_q   [2];
  logic [ProdW-1:0]   mcand_q [2];
  logic [TimeW-1:0]   rem_q   [2];
  logic               neg_q   [2];
  logic [StepW-1:0]   step_q;

  // Output word
  logic                             out_valid_q;
  logic signed [phi_pkg::LatW-1:0]  lat_out_q;
  logic signed [phi_pkg::LonW-1:0]  lon_out_q;
  logic                             interp_q;

  logic                    keep, we, full;
  logic [IdxW:0]           wsum, rsum;
  logic [IdxW-1:0]         waddr, raddr;
  phi_pkg::entry_t         wdata;
  logic signed [DiffW-1:0] av [2];
  logic signed [DiffW-1:0] bv [2];
  logic signed [DiffW-1:0] res [2];

  // Ring slot arithmetic, wrapped at the depth
  assign full  = (count_q == CntW'(HistoryDepth));
  assign wsum  = {1'b0, oldest_q} + {1'b0, count_q[IdxW-1:0]};
  assign rsum  = {1'b0, oldest_q} + {1'b0, pos_q};
  assign waddr = full ? oldest_q :
                 (wsum >= (IdxW+1)'(HistoryDepth)) ? IdxW'(wsum - (IdxW+1)'(HistoryDepth))
                                                   : wsum[IdxW-1:0];
  assign raddr = (rsum >= (IdxW+1)'(HistoryDepth)) ? IdxW'(rsum - (IdxW+1)'(HistoryDepth))
                                                   : rsum[IdxW-1:0];

  assign keep  = (fix_quality_i != '0) && (lat_in_i != '0) && (lon_in_i != '0);
  assign we    = cmd_i.add_we && keep;
  assign wdata = '{lat: lat_in_i, lon: lon_in_i, tm: time_ms_i};

  phi_ram #(
    .Width (phi_pkg::EntryW),
    .Depth (HistoryDepth)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Sign-extended pair coordinates and final a +/- q per lane
  always_comb begin
    av[0] = DiffW'(a_q.lat);
    bv[0] = DiffW'(b_q.lat);
    av[1] = DiffW'(a_q.lon);
    bv[1] = DiffW'(b_q.lon);
    for (int l = 0; l < 2; l++) begin
      res[l] = neg_q[l] ? av[l] - signed'(acc_q[l][DiffW-1:0])
                        : av[l] + signed'(acc_q[l][DiffW-1:0]);
    end
  end

  // Ring pointers and current position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oldest_q  <= '0;
      count_q   <= '0;
      cur_lat_q <= '0;
      cur_lon_q <= '0;
    end else if (cmd_i.add_we) begin
      cur_lat_q <= lat_in_i;
      cur_lon_q <= lon_in_i;
      if (keep) begin
        if (full) begin
          oldest_q <= (oldest_q == IdxW'(HistoryDepth - 1)) ? '0 : oldest_q + IdxW'(1);
        end else begin
          count_q <= count_q + CntW'(1);
        end
      end
    end
  end

  // Walk over neighboring pairs
  always_ff @(posedge clk_i) begin
    if (cmd_i.query_ld) begin
      t_q   <= time_ms_i;
      pos_q <= '0;
    end
    if (cmd_i.ld_first) begin
      a_q   <= rdata;
      o_q   <= rdata;
      pos_q <= IdxW'(1);
    end
    if (cmd_i.ld_pair) begin
      b_q    <= rdata;
      brk_q  <= (a_q.tm <= t_q) && (rdata.tm >= t_q);
      eq_q   <= (a_q.tm == rdata.tm);
      tge_q  <= (t_q >= rdata.tm);
      last_q <= (CntW'({1'b0, pos_q}) + CntW'(1)) == count_q;
    end
    if (cmd_i.advance) begin
      a_q   <= b_q;
      pos_q <= pos_q + IdxW'(1);
    end
  end

  // Shift-add multiply, then restoring divide in place of the product
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_init) begin
      mplier_q <= t_q - a_q.tm;
      den_q    <= b_q.tm - a_q.tm;
      step_q   <= '0;
      for (int l = 0; l < 2; l++) begin
        neg_q[l]   <= (bv[l] < av[l]);
        mcand_q[l] <= (bv[l] < av[l]) ? ProdW'(unsigned'(av[l] - bv[l]))
                                      : ProdW'(unsigned'(bv[l] - av[l]));
        acc_q[l]   <= '0;
      end
    end else if (cmd_i.mul_step) begin
      mplier_q <= mplier_q >> 1;
      for (int l = 0; l < 2; l++) begin
        if (mplier_q[0]) begin
          acc_q[l] <= acc_q[l] + mcand_q[l];
        end
        mcand_q[l] <= mcand_q[l] << 1;
      end
    end else if (cmd_i.div_step) begin
      for (int l = 0; l < 2; l++) begin
        if ({rem_q[l], acc_q[l][ProdW-1]} >= {1'b0, den_q}) begin
          rem_q[l] <= TimeW'({rem_q[l], acc_q[l][ProdW-1]} - {1'b0, den_q});
          acc_q[l] <= {acc_q[l][ProdW-2:0], 1'b1};
        end else begin
          rem_q[l] <= {rem_q[l][TimeW-2:0], acc_q[l][ProdW-1]};
          acc_q[l] <= {acc_q[l][ProdW-2:0], 1'b0};
        end
      end
    end
    if (cmd_i.div_init) begin
      step_q <= '0;
      for (int l = 0; l < 2; l++) begin
        rem_q[l] <= '0;
      end
    end else if (cmd_i.mul_step || cmd_i.div_step) begin
      step_q <= step_q + StepW'(1);
    end
  end

  // Output word valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output word payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      interp_q <= 1'b0;
      case (cmd_i.sel)
        phi_pkg::SelCur: begin
          lat_out_q <= cur_lat_q;
          lon_out_q <= cur_lon_q;
        end
        phi_pkg::SelFirst: begin
          lat_out_q <= a_q.lat;
          lon_out_q <= a_q.lon;
        end
        phi_pkg::SelNewest: begin
          lat_out_q <= b_q.lat;
          lon_out_q <= b_q.lon;
        end
        phi_pkg::SelOldest: begin
          lat_out_q <= o_q.lat;
          lon_out_q <= o_q.lon;
        end
        phi_pkg::SelInterp: begin
          lat_out_q <= res[0][phi_pkg::LatW-1:0];
          lon_out_q <= res[1][phi_pkg::LonW-1:0];
          interp_q  <= 1'b1;
        end
        default: begin
          lat_out_q <= cur_lat_q;
          lon_out_q <= cur_lon_q;
        end
      endcase
    end
  end

  assign stat_o = '{
    cnt_zero: (count_q == '0),
    cnt_one:  (count_q == CntW'(1)),
    brk:      brk_q,
    eq:       eq_q,
    last:     last_q,
    tge:      tge_q,
    mul_last: (step_q == StepW'(phi_pkg::MulSteps - 1)),
    div_last: (step_q == StepW'(phi_pkg::DivSteps - 1)),
    out_free: (!out_valid_q || out_ready_i)
  };

  assign out_valid_o    = out_valid_q;
  assign lat_out_o      = lat_out_q;
  assign lon_out_o      = lon_out_q;
  assign interp_valid_o = interp_q;

endmodule

// File: hdl/position_history_interpolator_unit.sv
// Top level of the position history interpolator: controller plus datapath.
// Depends on phi_pkg, phi_ctrl, phi_dp (and phi_ram below it).
//
//   channel | handshake              | payload
//   in      | in_valid_i / in_ready_o  | command_i lat_in_i lon_in_i fix_quality_i time_ms_i
//   out     | out_valid_o / out_ready_i | lat_out_o lon_out_o interp_valid_o
//
// An add word is handled in the idle state. A query on an empty history goes
// straight to loading the output word; any other query walks the history pairs
// through the single read port of the history RAM, then multiplies and divides
// bit-serially when it interpolates, and then loads the output word. Reset
// clears pointers, the current position and all control; history RAM
// contents are not cleared.
// A stalled output word holds; a finished query waits for it before loading.
module position_history_interpolator_unit #(
  parameter int HistoryDepth = phi_pkg::HistoryDepthDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              command_i,
  input  logic signed [phi_pkg::LatW-1:0]   lat_in_i,
  input  logic signed [phi_pkg::LonW-1:0]   lon_in_i,
  input  logic [phi_pkg::QualW-1:0]         fix_quality_i,
  input  logic [phi_pkg::TimeW-1:0]         time_ms_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [phi_pkg::LatW-1:0]   lat_out_o,
  output logic signed [phi_pkg::LonW-1:0]   lon_out_o,
  output logic                              interp_valid_o
);

  `include "position_history_interpolator_unit_assert.svh"

  phi_pkg::dp_cmd_t  cmd;
  phi_pkg::dp_stat_t stat;

  phi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .command_i  (command_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  phi_dp #(
    .HistoryDepth (HistoryDepth)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .lat_in_i       (lat_in_i),
    .lon_in_i       (lon_in_i),
    .fix_quality_i  (fix_quality_i),
    .time_ms_i      (time_ms_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .lat_out_o      (lat_out_o),
    .lon_out_o      (lon_out_o),
    .interp_valid_o (interp_valid_o)
  );

  // A query keeps the block busy for at least the next cycle
  `PHI_ASSERT_NXT(a_query_busy, in_valid_i && in_ready_o && command_i == phi_pkg::CmdQuery, !in_ready_o)
  // An add never produces an output word
  `PHI_ASSERT_NXT(a_add_silent, in_valid_i && in_ready_o && command_i == phi_pkg::CmdAdd && !out_valid_o, !out_valid_o)
  // A new output word is only loaded while the input side is busy
  `PHI_ASSERT_NOW(a_load_busy, $rose(out_valid_o), $past(!in_ready_o))

endmodule
